[hdl/ipms_pkg.sv]
// ----------------------------------------------------------------------------
// ipms_pkg
// Shared types and constants of the two-motor incremental PI speed controller.
// ----------------------------------------------------------------------------
package ipms_pkg;

  // default thresholds (integer counts)
  localparam int INT_WINDOW_LO_DEF = -50;
  localparam int INT_WINDOW_HI_DEF = 50;
  localparam int INT_TERM_LO_DEF   = -100;
  localparam int INT_TERM_HI_DEF   = 100;
  localparam int DELTA_ERR_LO_DEF  = -20;
  localparam int DELTA_ERR_HI_DEF  = 20;

  // error at or above this uses the large gain pair
  localparam int ERR_LARGE         = 15;
  // setpoint below this with a stopped motor kills the integral term
  localparam int TARGET_IDLE_LIMIT = 11;

  // configuration register indexes
  localparam logic [2:0] REG_GAIN_P_LARGE = 3'd0;
  localparam logic [2:0] REG_GAIN_I_LARGE = 3'd1;
  localparam logic [2:0] REG_GAIN_P_SMALL = 3'd2;
  localparam logic [2:0] REG_GAIN_I_SMALL = 3'd3;
  localparam logic [2:0] REG_GAIN_P_BRAKE = 3'd4;
  localparam logic [2:0] REG_GAIN_I_BRAKE = 3'd5;
  localparam logic [2:0] REG_DUTY_FLOOR   = 3'd6;
  localparam logic [2:0] REG_DUTY_CEILING = 3'd7;

  localparam logic signed [15:0] DUTY_CEILING_RST = 16'sd1000;

  // Q8.8 gain set
  typedef struct packed {
    logic [15:0] p_large;
    logic [15:0] i_large;
    logic [15:0] p_small;
    logic [15:0] i_small;
    logic [15:0] p_brake;
    logic [15:0] i_brake;
  } gains_t;

  // per-motor state entry
  typedef struct packed {
    logic signed [16:0] prev_err;
    logic signed [31:0] acc;
  } state_t;

endpackage

[hdl/ipms_pi_terms.sv]
// ----------------------------------------------------------------------------
// ipms_pi_terms
// Gain selection, integral window and clamp, error-change clamp, P and I products.
// ----------------------------------------------------------------------------
module ipms_pi_terms #(
  parameter int INT_WINDOW_LO = ipms_pkg::INT_WINDOW_LO_DEF,
  parameter int INT_WINDOW_HI = ipms_pkg::INT_WINDOW_HI_DEF,
  parameter int INT_TERM_LO   = ipms_pkg::INT_TERM_LO_DEF,
  parameter int INT_TERM_HI   = ipms_pkg::INT_TERM_HI_DEF,
  parameter int DELTA_ERR_LO  = ipms_pkg::DELTA_ERR_LO_DEF,
  parameter int DELTA_ERR_HI  = ipms_pkg::DELTA_ERR_HI_DEF
) (
  input  ipms_pkg::gains_t   gains,
  input  logic signed [16:0] err,
  input  logic signed [16:0] prev_err,
  input  logic               i_kill,
  output logic signed [34:0] p_term,
  output logic signed [23:0] i_term
);

  localparam logic signed [17:0] WIN_LO   = 18'(INT_WINDOW_LO);
  localparam logic signed [17:0] WIN_HI   = 18'(INT_WINDOW_HI);
  localparam logic signed [33:0] ITERM_LO = 34'(INT_TERM_LO * 256);
  localparam logic signed [33:0] ITERM_HI = 34'(INT_TERM_HI * 256);
  localparam logic signed [17:0] DLT_LO   = 18'(DELTA_ERR_LO);
  localparam logic signed [17:0] DLT_HI   = 18'(DELTA_ERR_HI);
  localparam logic signed [16:0] E_LARGE  = 17'(ipms_pkg::ERR_LARGE);

  logic [15:0]        gp;
  logic [15:0]        gi;
  logic signed [17:0] err_x;
  logic signed [17:0] dlt;
  logic signed [17:0] dlt_c;
  logic signed [33:0] prod_i;
  logic signed [33:0] prod_i_c;
  logic               in_window;

  always_comb begin
    if (err >= E_LARGE) begin
      gp = gains.p_large;
      gi = gains.i_large;
    end else if (!err[16]) begin
      gp = gains.p_small;
      gi = gains.i_small;
    end else begin
      gp = gains.p_brake;
      gi = gains.i_brake;
    end
  end

  assign err_x     = {err[16], err};
  assign in_window = (err_x < WIN_HI) && (err_x > WIN_LO);

  assign prod_i = $signed({1'b0, gi}) * err;

  always_comb begin
    if (prod_i < ITERM_LO) begin
      prod_i_c = ITERM_LO;
    end else if (prod_i > ITERM_HI) begin
      prod_i_c = ITERM_HI;
    end else begin
      prod_i_c = prod_i;
    end
  end

  assign i_term = (in_window && !i_kill) ? prod_i_c[23:0] : 24'sd0;

  assign dlt = err_x - $signed({prev_err[16], prev_err});

  always_comb begin
    if (dlt < DLT_LO) begin
      dlt_c = DLT_LO;
    end else if (dlt > DLT_HI) begin
      dlt_c = DLT_HI;
    end else begin
      dlt_c = dlt;
    end
  end

  assign p_term = $signed({1'b0, gp}) * dlt_c;

endmodule

[hdl/incremental_pi_motor_speed_top.sv]
// ----------------------------------------------------------------------------
// incremental_pi_motor_speed_top
// Two-motor incremental PI speed controller with per-motor state in a RAM.
// ----------------------------------------------------------------------------
// One item per clock sustained while out_tready keeps the output open. An
// accepted item's state RAM read is registered together with it, the gain
// multiplies work from those registers into stage 2, then the accumulate/clamp
// with RAM write-back loads the output register. Items for the same
// motor may follow each other in consecutive cycles; writes still in flight
// are snooped into the read data and the previous error is forwarded from the
// item ahead. State resets to zero through per-entry valid bits, so no clearing
// pass is needed and the block is ready right after reset.
module incremental_pi_motor_speed_top #(
  parameter int INT_WINDOW_LO = ipms_pkg::INT_WINDOW_LO_DEF,
  parameter int INT_WINDOW_HI = ipms_pkg::INT_WINDOW_HI_DEF,
  parameter int INT_TERM_LO   = ipms_pkg::INT_TERM_LO_DEF,
  parameter int INT_TERM_HI   = ipms_pkg::INT_TERM_HI_DEF,
  parameter int DELTA_ERR_LO  = ipms_pkg::DELTA_ERR_LO_DEF,
  parameter int DELTA_ERR_HI  = ipms_pkg::DELTA_ERR_HI_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] target_speed, [31:16] measured_speed
  input  logic        in_tuser,   // [0] motor_select
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [15:0] duty_out, [47:16] step_increment,
                                  // [48] duty_clamped, [55:49] zero
  output logic        out_tuser,  // [0] motor_id
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wr_data
);

  localparam logic signed [15:0] TGT_IDLE = 16'(ipms_pkg::TARGET_IDLE_LIMIT);

  // configuration
  ipms_pkg::gains_t   gains_r;
  logic signed [15:0] floor_r;
  logic signed [15:0] ceil_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r <= '0;
      floor_r <= 16'sd0;
      ceil_r  <= ipms_pkg::DUTY_CEILING_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ipms_pkg::REG_GAIN_P_LARGE: gains_r.p_large <= cfg_wr_data;
        ipms_pkg::REG_GAIN_I_LARGE: gains_r.i_large <= cfg_wr_data;
        ipms_pkg::REG_GAIN_P_SMALL: gains_r.p_small <= cfg_wr_data;
        ipms_pkg::REG_GAIN_I_SMALL: gains_r.i_small <= cfg_wr_data;
        ipms_pkg::REG_GAIN_P_BRAKE: gains_r.p_brake <= cfg_wr_data;
        ipms_pkg::REG_GAIN_I_BRAKE: gains_r.i_brake <= cfg_wr_data;
        ipms_pkg::REG_DUTY_FLOOR:   floor_r         <= cfg_wr_data;
        ipms_pkg::REG_DUTY_CEILING: ceil_r          <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic s1_v_r, s2_v_r, out_v_r;
  logic en_out, en_s2, en_s1, in_acc, wr_en;

  assign en_out    = !out_v_r || out_tready;
  assign en_s2     = !s2_v_r || en_out;
  assign en_s1     = !s1_v_r || en_s2;
  assign in_tready = en_s1;
  assign in_acc    = in_tvalid && en_s1;
  assign wr_en     = s2_v_r && en_out;

  // input decode
  logic               in_m;
  logic signed [15:0] in_tgt, in_meas;
  assign in_m    = in_tuser;
  assign in_tgt  = in_tdata[15:0];
  assign in_meas = in_tdata[31:16];

  // state RAM
  ipms_pkg::state_t mem_r [2];
  logic [1:0]       vld_r;
  ipms_pkg::state_t q_r;
  logic             q_v_r;
  logic             wr_m;
  ipms_pkg::state_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_m] <= wr_data;
    end
    if (in_acc) begin
      q_r <= mem_r[in_m];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 2'b00;
      q_v_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_m] <= 1'b1;
      end
      if (in_acc) begin
        q_v_r <= vld_r[in_m];
      end
    end
  end

  // stage 1: error, snooped state, products
  logic               s1_m_r;
  logic signed [16:0] s1_e_r;
  logic               s1_kill_r;
  logic               s1_fix_r;
  ipms_pkg::state_t   s1_fix_d_r;
  ipms_pkg::state_t   s1_rd;
  logic signed [16:0] s1_prev;
  logic signed [34:0] s1_p;
  logic signed [23:0] s1_i;

  // s2 / output registers declared ahead for forwarding
  logic               s2_m_r;
  logic signed [16:0] s2_e_r;
  logic signed [34:0] s2_p_r;
  logic signed [23:0] s2_i_r;
  logic signed [31:0] s2_base_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_m_r    <= in_m;
      s1_e_r    <= $signed({in_tgt[15], in_tgt}) - $signed({in_meas[15], in_meas});
      s1_kill_r <= (in_meas == 16'sd0) && (in_tgt < TGT_IDLE);
    end
  end

  // keep the read data current with writes that land after the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_fix_r <= 1'b0;
    end else if (in_acc) begin
      s1_fix_r <= wr_en && (wr_m == in_m);
    end else if (s1_v_r && wr_en && (wr_m == s1_m_r)) begin
      s1_fix_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc || (s1_v_r && wr_en && (wr_m == s1_m_r))) begin
      s1_fix_d_r <= wr_data;
    end
  end

  always_comb begin
    if (s1_fix_r) begin
      s1_rd = s1_fix_d_r;
    end else if (q_v_r) begin
      s1_rd = q_r;
    end else begin
      s1_rd = '0;
    end
  end

  assign s1_prev = (s2_v_r && (s2_m_r == s1_m_r)) ? s2_e_r : s1_rd.prev_err;

  ipms_pi_terms #(
    .INT_WINDOW_LO (INT_WINDOW_LO),
    .INT_WINDOW_HI (INT_WINDOW_HI),
    .INT_TERM_LO   (INT_TERM_LO),
    .INT_TERM_HI   (INT_TERM_HI),
    .DELTA_ERR_LO  (DELTA_ERR_LO),
    .DELTA_ERR_HI  (DELTA_ERR_HI)
  ) u_terms (
    .gains    (gains_r),
    .err      (s1_e_r),
    .prev_err (s1_prev),
    .i_kill   (s1_kill_r),
    .p_term   (s1_p),
    .i_term   (s1_i)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en_s1) begin
        s1_v_r <= in_tvalid;
      end
      if (en_s2) begin
        s2_v_r <= s1_v_r;
      end
      if (en_out) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_s2 && s1_v_r) begin
      s2_m_r    <= s1_m_r;
      s2_e_r    <= s1_e_r;
      s2_p_r    <= s1_p;
      s2_i_r    <= s1_i;
      s2_base_r <= (wr_en && (wr_m == s1_m_r)) ? wr_data.acc : s1_rd.acc;
    end
  end

  // stage 2: saturate increment, accumulate, clamp, write back
  logic signed [35:0] sum;
  logic signed [31:0] inc;
  logic signed [32:0] acc_raw, acc_c, lo, hi;
  logic               clamped;

  assign sum = {s2_p_r[34], s2_p_r} + {{12{s2_i_r[23]}}, s2_i_r};

  always_comb begin
    if (sum[35:31] == 5'b00000 || sum[35:31] == 5'b11111) begin
      inc = sum[31:0];
    end else if (!sum[35]) begin
      inc = 32'sh7FFF_FFFF;
    end else begin
      inc = 32'sh8000_0000;
    end
  end

  assign acc_raw = {s2_base_r[31], s2_base_r} + {inc[31], inc};
  assign lo      = {{9{floor_r[15]}}, floor_r, 8'h00};
  assign hi      = {{9{ceil_r[15]}}, ceil_r, 8'h00};

  // floor first, ceiling wins
  always_comb begin
    acc_c   = acc_raw;
    clamped = 1'b0;
    if (acc_raw < lo) begin
      acc_c   = lo;
      clamped = 1'b1;
    end
    if (acc_c > hi) begin
      acc_c   = hi;
      clamped = 1'b1;
    end
  end

  assign wr_m             = s2_m_r;
  assign wr_data.prev_err = s2_e_r;
  assign wr_data.acc      = acc_c[31:0];

  // output register
  logic        out_m_r;
  logic [15:0] out_duty_r;
  logic [31:0] out_inc_r;
  logic        out_clamp_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      out_m_r     <= s2_m_r;
      out_duty_r  <= acc_c[23:8];
      out_inc_r   <= inc;
      out_clamp_r <= clamped;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_m_r;
  assign out_tdata  = {7'd0, out_clamp_r, out_inc_r, out_duty_r};

  // checks
  a_accept_fills_s1 : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_v_r)
    else $error("accepted item did not enter stage 1");

  a_write_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> out_v_r)
    else $error("state write without a result");

  a_write_needs_room : assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (!out_v_r || out_tready))
    else $error("state written while output register is blocked");

endmodule

[verif/tb_incremental_pi_motor_speed_top.sv]
// ----------------------------------------------------------------------------
// tb_incremental_pi_motor_speed_top
// Self-checking bench for the two-motor incremental PI speed controller. A
// bit-exact predictor tracks per-motor error and duty state, and every
// result is checked in order against it. The run covers several gain and
// duty-limit settings under mixed source and sink backpressure.
// ----------------------------------------------------------------------------
module tb_incremental_pi_motor_speed_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 10;
  localparam int PHASE_ITEMS    = 500;
  localparam int REPORT_LIMIT   = 10;
  localparam longint INC_MAX    = (longint'(1) <<< 31) - 1;
  localparam longint INC_MIN    = -(longint'(1) <<< 31);

  typedef struct {
    logic        motor;
    logic [15:0] duty;
    logic [31:0] incr;
    logic        clamped;
  } duty_result_t;

  // Predicts duty results from accepted samples and checks them in order
  class duty_scoreboard;
    ipms_pkg::gains_t   gains;
    logic signed [15:0] duty_floor;
    logic signed [15:0] duty_ceiling;
    logic signed [16:0] prev_err [2];
    logic signed [31:0] duty_acc [2];
    duty_result_t       expected_duties [$];
    int                 mismatches;
    int                 results_checked;
    int                 clamp_hits;

    function new();
      gains           = '0;
      duty_floor      = '0;
      duty_ceiling    = ipms_pkg::DUTY_CEILING_RST;
      prev_err[0]     = '0;
      prev_err[1]     = '0;
      duty_acc[0]     = '0;
      duty_acc[1]     = '0;
      mismatches      = 0;
      results_checked = 0;
      clamp_hits      = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        ipms_pkg::REG_GAIN_P_LARGE: gains.p_large = val;
        ipms_pkg::REG_GAIN_I_LARGE: gains.i_large = val;
        ipms_pkg::REG_GAIN_P_SMALL: gains.p_small = val;
        ipms_pkg::REG_GAIN_I_SMALL: gains.i_small = val;
        ipms_pkg::REG_GAIN_P_BRAKE: gains.p_brake = val;
        ipms_pkg::REG_GAIN_I_BRAKE: gains.i_brake = val;
        ipms_pkg::REG_DUTY_FLOOR:   duty_floor    = val;
        ipms_pkg::REG_DUTY_CEILING: duty_ceiling  = val;
        default: ;
      endcase
    endfunction

    function void note_sample(logic motor, logic signed [15:0] target,
                              logic signed [15:0] meas);
      longint       tgt, mes, e, gp, gi, iterm, d, pterm, inc, acc, lo, hi, ipart;
      longint       iterm_lo, iterm_hi;
      bit           clamped;
      duty_result_t r;
      tgt = target;
      mes = meas;
      e   = tgt - mes;
      if (e >= ipms_pkg::ERR_LARGE) begin
        gp = gains.p_large;
        gi = gains.i_large;
      end else if (e >= 0) begin
        gp = gains.p_small;
        gi = gains.i_small;
      end else begin
        gp = gains.p_brake;
        gi = gains.i_brake;
      end

      iterm    = 0;
      iterm_lo = longint'(ipms_pkg::INT_TERM_LO_DEF) * 256;
      iterm_hi = longint'(ipms_pkg::INT_TERM_HI_DEF) * 256;
      if (e < ipms_pkg::INT_WINDOW_HI_DEF && e > ipms_pkg::INT_WINDOW_LO_DEF) begin
        iterm = gi * e;
        if (iterm < iterm_lo) iterm = iterm_lo;
        if (iterm > iterm_hi) iterm = iterm_hi;
        // stopped motor with a low setpoint: no integral action
        if (mes == 0 && tgt < ipms_pkg::TARGET_IDLE_LIMIT) iterm = 0;
      end

      d = e - longint'(prev_err[motor]);
      if (d < ipms_pkg::DELTA_ERR_LO_DEF) d = ipms_pkg::DELTA_ERR_LO_DEF;
      if (d > ipms_pkg::DELTA_ERR_HI_DEF) d = ipms_pkg::DELTA_ERR_HI_DEF;
      pterm = gp * d;

      inc = pterm + iterm;
      if (inc > INC_MAX) inc = INC_MAX;
      if (inc < INC_MIN) inc = INC_MIN;

      acc     = longint'(duty_acc[motor]) + inc;
      lo      = longint'(duty_floor) * 256;
      hi      = longint'(duty_ceiling) * 256;
      clamped = 1'b0;
      // floor first, so an inverted pair ends on the ceiling
      if (acc < lo) begin
        acc     = lo;
        clamped = 1'b1;
      end
      if (acc > hi) begin
        acc     = hi;
        clamped = 1'b1;
      end

      prev_err[motor] = e[16:0];
      duty_acc[motor] = acc[31:0];
      ipart           = acc >>> 8;

      r.motor   = motor;
      r.duty    = ipart[15:0];
      r.incr    = inc[31:0];
      r.clamped = clamped;
      if (clamped) clamp_hits++;
      expected_duties.push_back(r);
    endfunction

    function int pending();
      return expected_duties.size();
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("MISMATCH: %s", what);
    endfunction

    function void check_duty(logic motor, logic [15:0] duty, logic [31:0] incr,
                             logic clamped);
      duty_result_t want;
      if (expected_duties.size() == 0) begin
        flag($sformatf("result with nothing pending: motor %0b duty %0d", motor,
                       $signed(duty)));
        return;
      end
      want = expected_duties.pop_front();
      results_checked++;
      if (motor !== want.motor || duty !== want.duty || incr !== want.incr ||
          clamped !== want.clamped)
        flag($sformatf({"motor exp %0b got %0b, duty exp %0d got %0d, ",
                        "increment exp %0d got %0d, clamped exp %0b got %0b"},
                       want.motor, motor, $signed(want.duty), $signed(duty),
                       $signed(want.incr), $signed(incr), want.clamped, clamped));
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata    = '0;  // [15:0] target_speed, [31:16] measured_speed
  logic        in_tuser    = 1'b0; // [0] motor_select
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [55:0] out_tdata;         // [15:0] duty_out, [47:16] step_increment,
                                  // [48] duty_clamped, [55:49] zero
  logic        out_tuser;         // [0] motor_id
  logic        cfg_wr_en   = 1'b0;
  logic [2:0]  cfg_index   = '0;
  logic [15:0] cfg_wr_data = '0;

  duty_scoreboard sb = new();
  int send_idle_pct  = 0;
  int sink_stall_pct = 0;
  int items_sent     = 0;
  int settings_used  = 0;

  incremental_pi_motor_speed_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result sink: check accepted items, then pick next cycle's ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_duty(out_tuser, out_tdata[15:0], out_tdata[47:16], out_tdata[48]);
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("tb_incremental_pi_motor_speed_top failed");
    $finish;
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_settings(logic [15:0] p_large, logic [15:0] i_large,
                                logic [15:0] p_small, logic [15:0] i_small,
                                logic [15:0] p_brake, logic [15:0] i_brake,
                                logic [15:0] floor_val, logic [15:0] ceil_val);
    write_reg(ipms_pkg::REG_GAIN_P_LARGE, p_large);
    write_reg(ipms_pkg::REG_GAIN_I_LARGE, i_large);
    write_reg(ipms_pkg::REG_GAIN_P_SMALL, p_small);
    write_reg(ipms_pkg::REG_GAIN_I_SMALL, i_small);
    write_reg(ipms_pkg::REG_GAIN_P_BRAKE, p_brake);
    write_reg(ipms_pkg::REG_GAIN_I_BRAKE, i_brake);
    write_reg(ipms_pkg::REG_DUTY_FLOOR, floor_val);
    write_reg(ipms_pkg::REG_DUTY_CEILING, ceil_val);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  task automatic send_sample(logic motor, logic signed [15:0] target,
                             logic signed [15:0] meas);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {meas, target};
    in_tuser  <= motor;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_sample(motor, target, meas);
    items_sent++;
  endtask

  // mostly errors near the gain and window thresholds, some full-range noise
  task automatic send_random();
    logic              motor;
    int                pick, e;
    logic signed [15:0] tgt, mes;
    motor = 1'($urandom_range(1));
    pick  = $urandom_range(99);
    if (pick < 55) begin
      tgt = 16'(int'($urandom_range(600)) - 300);
      mes = 16'(tgt - (int'($urandom_range(140)) - 70));
    end else if (pick < 65) begin
      tgt = 16'(int'($urandom_range(40)) - 20);
      mes = '0;
    end else if (pick < 75) begin
      case ($urandom_range(7))
        0:       e = 14;
        1:       e = 15;
        2:       e = 0;
        3:       e = -1;
        4:       e = 49;
        5:       e = 50;
        6:       e = -49;
        default: e = -50;
      endcase
      tgt = 16'(int'($urandom_range(400)) - 200);
      mes = 16'(tgt - e);
    end else begin
      tgt = 16'($urandom());
      mes = 16'($urandom());
    end
    send_sample(motor, tgt, mes);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset gains are zero: duty must hold
    send_sample(1'b0, 16'sd200, 16'sd0);
    send_sample(1'b1, -16'sd5, 16'sd3);
    send_sample(1'b0, -16'sd300, 16'sd300);
    drain();

    apply_settings(16'h0180, 16'h0800, 16'h0100, 16'h0080, 16'h0200, 16'h0800,
                   -16'sd20, 16'sd30);
    send_sample(1'b0, 16'sd100, 16'sd85);     // large pair boundary
    send_sample(1'b0, 16'sd100, 16'sd86);     // small pair top
    send_sample(1'b0, 16'sd100, 16'sd100);
    send_sample(1'b0, 16'sd100, 16'sd101);    // brake pair
    send_sample(1'b0, 16'sd100, 16'sd51);     // window edge, I clamped high
    send_sample(1'b0, 16'sd100, 16'sd50);     // just outside window
    send_sample(1'b0, 16'sd0, 16'sd49);       // I clamped low
    send_sample(1'b0, 16'sd0, 16'sd50);
    send_sample(1'b0, 16'sd10, 16'sd0);       // stopped, low setpoint
    send_sample(1'b0, 16'sd11, 16'sd0);
    send_sample(1'b0, -16'sd32768, 16'sd0);
    send_sample(1'b0, 16'sd32767, -16'sd32768);
    send_sample(1'b0, -16'sd32768, 16'sd32767);
    send_sample(1'b0, 16'sd32767, 16'sd32767);
    send_sample(1'b0, -16'sd32768, -16'sd32768);
    send_sample(1'b1, 16'sd40, 16'sd0);
    send_sample(1'b1, 16'sd32767, -16'sd32768);  // drive up to the ceiling
    send_sample(1'b1, 16'sd32767, -16'sd32768);
    send_sample(1'b1, -16'sd32768, 16'sd32767);  // swing down to the floor
    send_sample(1'b1, -16'sd32768, 16'sd32767);
    drain();

    // floor above ceiling
    apply_settings(16'h0180, 16'h0800, 16'h0100, 16'h0080, 16'h0200, 16'h0800,
                   16'sd40, -16'sd40);
    send_sample(1'b0, 16'sd100, 16'sd60);
    send_sample(1'b1, -16'sd100, 16'sd60);
    send_sample(1'b0, 16'sd0, 16'sd0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          sink_stall_pct = 0;
          apply_settings(16'($urandom_range(1023)), 16'($urandom_range(1023)),
                         16'($urandom_range(1023)), 16'($urandom_range(1023)),
                         16'($urandom_range(1023)), 16'($urandom_range(1023)),
                         -16'sd1000, 16'sd1000);
        end
        1: begin
          send_idle_pct  = 49;
          sink_stall_pct = 0;
          apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'sh8000, 16'sh7FFF);
        end
        2: begin
          send_idle_pct  = 0;
          sink_stall_pct = 49;
          apply_settings(16'($urandom()), 16'($urandom()), 16'($urandom()),
                         16'($urandom()), 16'($urandom()), 16'($urandom()),
                         16'(-int'($urandom_range(3000))),
                         16'($urandom_range(3000)));
        end
        default: begin
          send_idle_pct  = 13;
          sink_stall_pct = 13;
          apply_settings(16'($urandom_range(2047)), 16'($urandom_range(2047)),
                         16'($urandom_range(2047)), 16'($urandom_range(2047)),
                         16'($urandom_range(2047)), 16'($urandom_range(2047)),
                         -16'sd300, 16'sd8000);
        end
      endcase
      repeat (PHASE_ITEMS) send_random();
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d items under %0d gain/limit settings, %0d results checked,",
             items_sent, settings_used, sb.results_checked);
    $display("%0d at a duty limit; backpressure mixes none, source, sink and both.",
             sb.clamp_hits);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_incremental_pi_motor_speed_top passed");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.pending());
      $display("tb_incremental_pi_motor_speed_top failed");
    end
    $finish;
  end

endmodule

[files.f]
hdl/ipms_pkg.sv
hdl/ipms_pi_terms.sv
hdl/incremental_pi_motor_speed_top.sv
verif/tb_incremental_pi_motor_speed_top.sv
